// File: rtl/fbpm_pkg.sv
// Shared types, codes and constants for the frame buffer pool manager.
package fbpm_pkg;

	// Sizes fixed by the field widths
	localparam int MAX_BUFFERS     = 64;
	localparam int MAX_WAITERS_DEF = 16;
	localparam int ID_W            = 7;
	localparam int TAG_W           = 4;
	localparam int CNT_W           = 32;
	localparam int FB_IW           = $clog2(MAX_BUFFERS);

	localparam logic [ID_W-1:0] POOL_MAX   = ID_W'(MAX_BUFFERS);
	localparam logic [ID_W-1:0] POOL_RESET = (8 > MAX_BUFFERS) ? ID_W'(MAX_BUFFERS) : ID_W'(8);

	// Register index (word address bit)
	localparam logic REG_POOL_SIZE = 1'b0;

	// Command codes
	localparam logic [1:0] CMD_TRY      = 2'd0;
	localparam logic [1:0] CMD_WAIT     = 2'd1;
	localparam logic [1:0] CMD_RELEASE  = 2'd2;
	localparam logic [1:0] CMD_SHUTDOWN = 2'd3;

	// Result status codes
	localparam logic [2:0] ST_GRANTED    = 3'd0;
	localparam logic [2:0] ST_NONE       = 3'd1;
	localparam logic [2:0] ST_DENIED     = 3'd2;
	localparam logic [2:0] ST_REL_ACK    = 3'd3;
	localparam logic [2:0] ST_SHUT_ACK   = 3'd4;
	localparam logic [2:0] ST_QUEUE_FULL = 3'd5;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [TAG_W-1:0] requester;
		logic [ID_W-1:0]  release_id;
	} request_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [TAG_W-1:0] client;
		logic [ID_W-1:0]  granted_id;
		logic [ID_W-1:0]  free_count;
		logic [ID_W-1:0]  busy_count;
		logic [ID_W-1:0]  peak_busy;
		logic [CNT_W-1:0] grant_total;
		logic [CNT_W-1:0] wait_total;
		logic             last;
	} response_t;

	// Datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_GRANT_REQ,
		OP_REPLY,
		OP_QUEUE,
		OP_RELEASE,
		OP_GRANT_WAITER,
		OP_DENY_WAITER
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] code;
		logic       last;
		logic       close;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       closed;
		logic       free_empty;
		logic       wq_empty;
		logic       wq_one;
		logic       wq_full;
		logic       rel_grant;
	} dp_stat_t;

	typedef struct packed {
		logic            wr;
		logic [ID_W-1:0] size;
	} cfg_wr_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_WAIT,
		S_GRANT,
		S_DENY,
		S_ACK
	} ctrl_state_t;

endpackage

// File: rtl/fbpm_ctrl.sv
// Controller state machine: sequences the datapath operations of one command.
module fbpm_ctrl import fbpm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output logic     busy,
	output dp_cmd_t  dcmd
);

	ctrl_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d    = state_q;
		dcmd.op    = OP_NONE;
		dcmd.code  = ST_GRANTED;
		dcmd.last  = 1'b0;
		dcmd.close = 1'b0;
		busy       = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					dcmd.op = OP_LOAD;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				unique case (stat.cmd)
					CMD_TRY, CMD_WAIT: begin
						dcmd.last = 1'b1;
						priority if (stat.closed) begin
							dcmd.op   = OP_REPLY;
							dcmd.code = ST_DENIED;
						end else if (!stat.free_empty) begin
							dcmd.op = OP_GRANT_REQ;
						end else if (stat.cmd == CMD_TRY) begin
							dcmd.op   = OP_REPLY;
							dcmd.code = ST_NONE;
						end else if (stat.wq_full) begin
							dcmd.op   = OP_REPLY;
							dcmd.code = ST_QUEUE_FULL;
						end else begin
							// queued waiter: no result now
							dcmd.op   = OP_QUEUE;
							dcmd.last = 1'b0;
						end
					end
					CMD_RELEASE: begin
						dcmd.op   = OP_RELEASE;
						dcmd.last = !stat.rel_grant;
						if (stat.rel_grant) begin
							state_d = S_WAIT;
						end
					end
					CMD_SHUTDOWN: begin
						dcmd.close = 1'b1;
						if (stat.wq_empty) begin
							dcmd.op   = OP_REPLY;
							dcmd.code = ST_SHUT_ACK;
							dcmd.last = 1'b1;
						end else begin
							dcmd.op = OP_DENY_WAITER;
							state_d = stat.wq_one ? S_ACK : S_DENY;
						end
					end
				endcase
			end
			S_WAIT: begin
				// let the free-list read pick up the id just released
				state_d = S_GRANT;
			end
			S_GRANT: begin
				dcmd.op   = OP_GRANT_WAITER;
				dcmd.last = 1'b1;
				state_d   = S_IDLE;
			end
			S_DENY: begin
				dcmd.op = OP_DENY_WAITER;
				state_d = stat.wq_one ? S_ACK : S_DENY;
			end
			S_ACK: begin
				dcmd.op   = OP_REPLY;
				dcmd.code = ST_SHUT_ACK;
				dcmd.last = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// The denial run only continues while waiters remain
	a_deny_has_waiter: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DENY |-> !stat.wq_empty)
		else $error("denial issued with empty waiter queue");

endmodule

// File: rtl/fbpm_datapath.sv
// Datapath: free-list memory, waiter queue, counters and the result register.
module fbpm_datapath import fbpm_pkg::*; #(
	parameter int MAX_WAITERS = MAX_WAITERS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  request_t        req_in,
	input  dp_cmd_t         dcmd,
	input  cfg_wr_t         cfg,
	output dp_stat_t        stat,
	output response_t       resp,
	output logic            resp_valid,
	output logic [ID_W-1:0] pool_size
);

	localparam int WIW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int WCW = $clog2(MAX_WAITERS + 1);
	localparam logic [WCW-1:0] WQ_DEPTH = WCW'(MAX_WAITERS);
	localparam logic [WIW:0]   WQ_WRAP  = (WIW + 1)'(MAX_WAITERS);
	localparam logic [WIW-1:0] WQ_LAST  = WIW'(MAX_WAITERS - 1);

	// Architectural state
	logic [ID_W-1:0]        pool_q;
	logic [FB_IW-1:0]       head_q;
	logic [ID_W-1:0]        fill_q;
	logic                   closed_q;
	logic [ID_W-1:0]        peak_q;
	logic [CNT_W-1:0]       grant_q;
	logic [CNT_W-1:0]       wait_q;
	logic [WIW-1:0]         whead_q;
	logic [WCW-1:0]         wfill_q;
	logic [MAX_BUFFERS-1:0] vld_q;
	logic [ID_W-1:0]        fl_mem [MAX_BUFFERS];
	logic [TAG_W-1:0]       wtags_q [MAX_WAITERS];

	// Latched item and registered free-list read
	request_t               item_q;
	logic [ID_W-1:0]        rd_q;
	logic                   rd_vld_q;
	logic [FB_IW-1:0]       rd_head_q;

	response_t              resp_q;
	logic                   resp_valid_q;

	// Next-state values
	logic                   pop_free, pop_wait, push_free, push_wait, rel_ok, emit;
	logic [ID_W-1:0]        fid;
	logic [ID_W-1:0]        fill_n, busy_n, peak_n;
	logic [FB_IW-1:0]       head_n, wr_addr;
	logic [CNT_W-1:0]       grant_n, wait_n;
	logic [WIW-1:0]         whead_n, wq_wr_idx;
	logic [WCW-1:0]         wfill_n;
	logic [WIW:0]           wq_sum;
	logic                   closed_n;

	// Decode the operation
	always_comb begin
		pop_free  = (dcmd.op == OP_GRANT_REQ) || (dcmd.op == OP_GRANT_WAITER);
		pop_wait  = (dcmd.op == OP_GRANT_WAITER) || (dcmd.op == OP_DENY_WAITER);
		push_wait = (dcmd.op == OP_QUEUE);
		rel_ok    = (item_q.release_id != '0) && (item_q.release_id <= pool_q) &&
			(fill_q < pool_q);
		push_free = (dcmd.op == OP_RELEASE) && rel_ok;
		emit      = (dcmd.op == OP_GRANT_REQ) || (dcmd.op == OP_REPLY) ||
			(dcmd.op == OP_RELEASE) || (dcmd.op == OP_GRANT_WAITER) ||
			(dcmd.op == OP_DENY_WAITER);
	end

	// Free list: entries never written since refill hold their index plus one
	always_comb begin
		fid     = rd_vld_q ? rd_q : (ID_W'(rd_head_q) + ID_W'(1));
		// pool depth is a power of two, so the tail address wraps by truncation
		wr_addr = head_q + fill_q[FB_IW-1:0];
		head_n  = pop_free ? (head_q + FB_IW'(1)) : head_q;
		fill_n  = fill_q;
		if (push_free) begin
			fill_n = fill_q + ID_W'(1);
		end else if (pop_free) begin
			fill_n = fill_q - ID_W'(1);
		end
		busy_n  = pool_q - fill_n;
		peak_n  = (pop_free && (busy_n > peak_q)) ? busy_n : peak_q;
		grant_n = (pop_free && (grant_q != '1)) ? (grant_q + CNT_W'(1)) : grant_q;
		wait_n  = (push_wait && (wait_q != '1)) ? (wait_q + CNT_W'(1)) : wait_q;
		closed_n = closed_q | dcmd.close;
	end

	// Waiter queue indexes, wrapped at the queue depth
	always_comb begin
		wq_sum    = (WIW + 1)'(whead_q) + (WIW + 1)'(wfill_q);
		wq_wr_idx = (wq_sum >= WQ_WRAP) ? WIW'(wq_sum - WQ_WRAP) : WIW'(wq_sum);
		whead_n   = whead_q;
		if (pop_wait) begin
			whead_n = (whead_q == WQ_LAST) ? '0 : (whead_q + WIW'(1));
		end
		wfill_n = wfill_q;
		if (push_wait) begin
			wfill_n = wfill_q + WCW'(1);
		end else if (pop_wait) begin
			wfill_n = wfill_q - WCW'(1);
		end
	end

	// Control state update; a configuration write refills the free list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q   <= POOL_RESET;
			head_q   <= '0;
			fill_q   <= POOL_RESET;
			vld_q    <= '0;
			closed_q <= 1'b0;
			peak_q   <= '0;
			grant_q  <= '0;
			wait_q   <= '0;
			whead_q  <= '0;
			wfill_q  <= '0;
		end else begin
			if (cfg.wr) begin
				pool_q <= cfg.size;
				head_q <= '0;
				fill_q <= cfg.size;
				vld_q  <= '0;
			end else begin
				head_q <= head_n;
				fill_q <= fill_n;
				if (push_free) begin
					vld_q[wr_addr] <= 1'b1;
				end
			end
			closed_q <= closed_n;
			peak_q   <= peak_n;
			grant_q  <= grant_n;
			wait_q   <= wait_n;
			whead_q  <= whead_n;
			wfill_q  <= wfill_n;
		end
	end

	// Free-list memory with registered read at the head
	always_ff @(posedge clk) begin
		if (push_free && !cfg.wr) begin
			fl_mem[wr_addr] <= item_q.release_id;
		end
		rd_q      <= fl_mem[head_q];
		rd_vld_q  <= vld_q[head_q];
		rd_head_q <= head_q;
	end

	// Waiter tags and the latched item
	always_ff @(posedge clk) begin
		if (push_wait) begin
			wtags_q[wq_wr_idx] <= item_q.requester;
		end
		if (dcmd.op == OP_LOAD) begin
			item_q <= req_in;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_valid_q <= 1'b0;
		end else begin
			resp_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			unique case (dcmd.op)
				OP_GRANT_REQ, OP_GRANT_WAITER: resp_q.status <= ST_GRANTED;
				OP_RELEASE:                    resp_q.status <= ST_REL_ACK;
				OP_DENY_WAITER:                resp_q.status <= ST_DENIED;
				default:                       resp_q.status <= dcmd.code;
			endcase
			resp_q.client      <= pop_wait ? wtags_q[whead_q] : item_q.requester;
			resp_q.granted_id  <= pop_free ? fid : '0;
			resp_q.free_count  <= fill_n;
			resp_q.busy_count  <= busy_n;
			resp_q.peak_busy   <= peak_n;
			resp_q.grant_total <= grant_n;
			resp_q.wait_total  <= wait_n;
			resp_q.last        <= dcmd.last;
		end
	end

	// Status back to the controller
	always_comb begin
		stat.cmd        = item_q.cmd;
		stat.closed     = closed_q;
		stat.free_empty = (fill_q == '0);
		stat.wq_empty   = (wfill_q == '0);
		stat.wq_one     = (wfill_q == WCW'(1));
		stat.wq_full    = (wfill_q >= WQ_DEPTH);
		stat.rel_grant  = (wfill_q != '0) && ((fill_q != '0) || rel_ok) && !closed_q;
	end

	assign resp       = resp_q;
	assign resp_valid = resp_valid_q;
	assign pool_size  = pool_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= pool_q)
		else $error("free list holds more ids than the pool size");

	a_wq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wfill_q <= WQ_DEPTH)
		else $error("waiter queue overflow");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop_free |-> fill_q != '0)
		else $error("grant issued from an empty free list");

	a_grant_id: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid_q && (resp_q.status == ST_GRANTED) |-> resp_q.granted_id != '0)
		else $error("grant carries buffer id zero");

endmodule

// File: rtl/frame_buffer_pool_manager_core.sv
// Top level of the frame buffer pool manager: command port, register port, core wiring.
//
// A command is taken when start is high and busy is low; results leave one per cycle on
// response with response_valid, and the receiver cannot stall them, so every result must be
// captured in the cycle it is shown. A try, blocking acquire or release keeps busy high in
// the execute state only, but a release that grants to a waiter also passes the wait and
// grant states, so the registered free-list read sees the returned id; a shutdown keeps it
// high while queued waiters are denied one per cycle. Each result appears in the cycle after
// the step that forms it. pool_size (byte address 0) is to be written through the APB port
// only while the block is idle; the block does not enforce this. A write refills the free
// list with ids 1..pool_size at once, with no sweep. Nothing is swept after reset either.
module frame_buffer_pool_manager_core import fbpm_pkg::*; #(
	parameter int MAX_WAITERS = MAX_WAITERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  request_t    request,
	output response_t   response,
	output logic        response_valid,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	dp_cmd_t         dcmd;
	dp_stat_t        stat;
	cfg_wr_t         cfg;
	logic [ID_W-1:0] pool_size;
	logic [ID_W-1:0] wr_val;
	logic            reg_hit;

	// Decode the register transfer and clamp the pool size into 1..MAX_BUFFERS
	always_comb begin
		reg_hit = (paddr[2] == REG_POOL_SIZE);
		wr_val  = pwdata[ID_W-1:0];
		cfg.wr  = psel && penable && pwrite && reg_hit;
		priority if (wr_val == '0) begin
			cfg.size = ID_W'(1);
		end else if (wr_val > POOL_MAX) begin
			cfg.size = POOL_MAX;
		end else begin
			cfg.size = wr_val;
		end
		prdata = reg_hit ? 32'(pool_size) : '0;
		pready = 1'b1;
	end

	fbpm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.dcmd   (dcmd)
	);

	fbpm_datapath #(
		.MAX_WAITERS (MAX_WAITERS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_in     (request),
		.dcmd       (dcmd),
		.cfg        (cfg),
		.stat       (stat),
		.resp       (response),
		.resp_valid (response_valid),
		.pool_size  (pool_size)
	);

endmodule
